### design/bvt_pkg.sv
// Package with the shared types and constants of the bounded vector table.
`default_nettype none

package bvt_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = 4;
   localparam int COUNT_W = 5;
   localparam int WORD_W  = 32;

   typedef enum logic [2:0] {
      KIND_APPEND     = 3'd0,
      KIND_POP        = 3'd1,
      KIND_READ       = 3'd2,
      KIND_INSERT     = 3'd3,
      KIND_REMOVE_AT  = 3'd4,
      KIND_REMOVE_ALL = 3'd5,
      KIND_FIND       = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     index;
      logic [WORD_W-1:0]     value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]     read_value;
      logic                  found;
      logic [ADDR_W-1:0]     found_position;
      status_type            status;
      logic [COUNT_W-1:0]    entry_count;
   } rsp_type;

endpackage

`default_nettype wire

### design/bvt_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bvt_ram #(
   parameter int ADDR_W = 4,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/bounded_vector_table.sv
// Top level of the bounded vector table: sequencer, entry count and result register.
//
//   Channel   Ports                                Direction  Transfer when
//   request   req_valid, req_stall, req_data       in         req_valid && !req_stall
//   response  rsp_valid, rsp_stall, rsp_data       out        rsp_valid && !rsp_stall
//   config    csr_wr_en, csr_wr_data               in         csr_wr_en
//
// One request is worked on at a time. Append, refused requests and the unused kind go
// straight to the final state; pop and read first fetch their one entry. Remove at,
// remove all and find walk the affected entries through the single RAM read port, one
// entry per cycle, then leave the walk, load the result register and hand it over. An
// insert also writes the new word into the opened gap, in a separate state, before that.
// Reset is synchronous and clears the count, the capacity register (to sixteen) and the
// control state; the entry RAM is not cleared and needs no clearing pass.
// A stalled response holds in its register; a new request is still taken meanwhile.
`default_nettype none

module bounded_vector_table import bvt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   // Control state.
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] capacity_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_ff, pend_in;
   logic [COUNT_W-1:0] walk_left_ff, walk_left_in;

   // Work registers of the request in flight.
   kind_type           kind_ff, kind_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0]  val_ff, val_in;
   status_type         status_ff, status_in;
   logic [WORD_W-1:0]  rdata_ff, rdata_in;
   logic               found_ff, found_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0]  walk_addr_ff, walk_addr_in;
   logic               walk_up_ff, walk_up_in;
   logic [ADDR_W-1:0]  paddr_ff, paddr_in;
   logic [COUNT_W-1:0] wptr_ff, wptr_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // RAM port signals.
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [WORD_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0]  mem_rd_data;

   // Helpers derived from the count and the capacity register.
   logic [COUNT_W-1:0] usable;
   logic               is_full;
   logic               idx_bad;
   logic [COUNT_W-1:0] count_dec;

   bvt_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // A capacity above the RAM depth behaves as the full depth.
   assign usable    = (capacity_ff > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : capacity_ff;
   assign is_full   = (count_ff >= usable);
   assign idx_bad   = ({1'b0, req_data.index} >= count_ff);
   assign count_dec = count_ff - 1'b1;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= COUNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         walk_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         walk_left_ff <= walk_left_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      rdata_ff     <= rdata_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      walk_addr_ff <= walk_addr_in;
      walk_up_ff   <= walk_up_in;
      paddr_ff     <= paddr_in;
      wptr_ff      <= wptr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // The walk keeps one read in flight. Shifts always write an address other than the
   // one being read in the same cycle, and compaction writes at or below the address
   // whose data has just arrived, so no forwarding is needed between the RAM ports.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = 1'b0;
      walk_left_in = walk_left_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      walk_addr_in = walk_addr_ff;
      walk_up_in   = walk_up_ff;
      paddr_in     = paddr_ff;
      wptr_in      = wptr_ff;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = val_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = walk_addr_ff;

      // The response register empties as soon as its transfer completes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in      = req_data.kind;
               idx_in       = req_data.index;
               val_in       = req_data.value;
               status_in    = STATUS_OK;
               rdata_in     = '0;
               found_in     = 1'b0;
               pos_in       = '0;
               wptr_in      = '0;
               walk_addr_in = '0;
               walk_left_in = '0;
               walk_up_in   = 1'b1;
               state_in     = ST_DONE;
               case (req_data.kind)
                  KIND_APPEND: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[ADDR_W-1:0];
                        mem_wr_data = req_data.value;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in     = count_dec;
                        walk_addr_in = count_dec[ADDR_W-1:0];
                        walk_left_in = COUNT_W'(1);
                        state_in     = ST_WALK;
                     end
                  end
                  KIND_READ: begin
                     if (idx_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        walk_addr_in = req_data.index;
                        walk_left_in = COUNT_W'(1);
                        state_in     = ST_WALK;
                     end
                  end
                  KIND_INSERT: begin
                     // The index check takes precedence over the full check.
                     if (idx_bad) begin
                        status_in = STATUS_RANGE;
                     end else if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        walk_addr_in = count_dec[ADDR_W-1:0];
                        walk_left_in = count_ff - {1'b0, req_data.index};
                        walk_up_in   = 1'b0;
                        state_in     = ST_WALK;
                     end
                  end
                  KIND_REMOVE_AT: begin
                     if (idx_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        count_in     = count_dec;
                        walk_addr_in = req_data.index + 1'b1;
                        walk_left_in = count_dec - {1'b0, req_data.index};
                        state_in     = ST_WALK;
                     end
                  end
                  KIND_REMOVE_ALL, KIND_FIND: begin
                     walk_left_in = count_ff;
                     state_in     = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (walk_left_ff != '0) begin
               mem_rd_en    = 1'b1;
               pend_in      = 1'b1;
               paddr_in     = walk_addr_ff;
               walk_left_in = walk_left_ff - 1'b1;
               walk_addr_in = walk_up_ff ? walk_addr_ff + 1'b1 : walk_addr_ff - 1'b1;
            end
            if (pend_ff) begin
               case (kind_ff)
                  KIND_POP, KIND_READ: begin
                     rdata_in = mem_rd_data;
                  end
                  KIND_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = paddr_ff + 1'b1;
                     mem_wr_data = mem_rd_data;
                  end
                  KIND_REMOVE_AT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = paddr_ff - 1'b1;
                     mem_wr_data = mem_rd_data;
                  end
                  KIND_REMOVE_ALL: begin
                     if (mem_rd_data != val_ff) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wptr_ff[ADDR_W-1:0];
                        mem_wr_data = mem_rd_data;
                        wptr_in     = wptr_ff + 1'b1;
                     end
                  end
                  KIND_FIND: begin
                     if (mem_rd_data == val_ff && !found_ff) begin
                        found_in = 1'b1;
                        pos_in   = paddr_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (walk_left_ff == '0 && !pend_ff) begin
               if (kind_ff == KIND_INSERT) begin
                  state_in = ST_PUT;
               end else begin
                  if (kind_ff == KIND_REMOVE_ALL) begin
                     count_in = wptr_ff;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         ST_PUT: begin
            // The gap is open: the new word goes in at the requested index.
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = val_ff;
            count_in    = count_ff + 1'b1;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.read_value     = rdata_ff;
               rsp_data_in.found          = found_ff;
               rsp_data_in.found_position = pos_ff;
               rsp_data_in.status         = status_ff;
               rsp_data_in.entry_count    = count_ff;
               state_in                   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The response register is only loaded on leaving the final state of a request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final state");

   // The stored count never exceeds the depth of the entry RAM.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count beyond RAM depth");

   // Reads and writes of the walk never touch the same entry in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("RAM read and write collide on one entry");

   // A successful append grows the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.kind == KIND_APPEND && !is_full)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the count");

endmodule

`default_nettype wire
